// ===== hw/rtl/c_comment_stripper_assert.svh =====
// Assertion macros shared by the comment stripper RTL.
`ifndef C_COMMENT_STRIPPER_ASSERT_SVH
`define C_COMMENT_STRIPPER_ASSERT_SVH

// Plain implication checked on every rising clock edge outside reset.
`define CCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds in the cycle after its trigger.
`define CCS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/ccs_pkg.sv =====
// Types and constants for the comment stripper.
package ccs_pkg;

  localparam logic [2:0] MODE_CODE       = 3'd0;
  localparam logic [2:0] MODE_SLASH      = 3'd1;
  localparam logic [2:0] MODE_LINE       = 3'd2;
  localparam logic [2:0] MODE_BLOCK      = 3'd3;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;
  localparam logic [2:0] MODE_QUOTE      = 3'd5;
  localparam logic [2:0] MODE_QUOTE_ESC  = 3'd6;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       eot;
  } ccs_res_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       qs;
  } ccs_state_t;

endpackage

// ===== hw/rtl/ccs_step.sv =====
// Next-state and result logic for one text byte.
module ccs_step import ccs_pkg::*; (
  input  ccs_state_t st,
  input  logic [7:0] ch,
  input  logic       is_final,
  output ccs_state_t st_nxt,
  output logic [1:0] res_cnt,
  output ccs_res_t   res0,
  output ccs_res_t   res1
);

  logic       is_q;
  logic       cb_emit;
  logic [2:0] cb_mode;
  logic       cb_qs;
  logic [7:0] quote_ch;

  // what a byte does when met in code mode
  assign is_q     = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
  assign cb_emit  = !((ch == CH_SLASH) || (ch == CH_HASH));
  assign cb_mode  = is_q ? MODE_QUOTE :
                    (ch == CH_SLASH) ? MODE_SLASH :
                    (ch == CH_HASH)  ? MODE_LINE  : MODE_CODE;
  assign cb_qs    = is_q ? (ch == CH_SQUOTE) : st.qs;
  assign quote_ch = st.qs ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    st_nxt  = st;
    res_cnt = 2'd0;
    res0    = '0;
    res1    = '0;
    case (st.mode)
      MODE_SLASH: begin
        if (ch == CH_SLASH) begin
          st_nxt.mode = MODE_LINE;
        end else if (ch == CH_STAR) begin
          st_nxt.mode = MODE_BLOCK;
        end else begin
          res0    = '{ch: CH_SLASH, vld: 1'b1, eot: 1'b0};
          res_cnt = 2'd1;
          if (cb_emit) begin
            res1    = '{ch: ch, vld: 1'b1, eot: 1'b0};
            res_cnt = 2'd2;
          end
          st_nxt.mode = cb_mode;
          st_nxt.qs   = cb_qs;
        end
      end
      MODE_LINE: begin
        if (ch == CH_NL) begin
          res0        = '{ch: CH_NL, vld: 1'b1, eot: 1'b0};
          res_cnt     = 2'd1;
          st_nxt.mode = MODE_CODE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if ((st.mode == MODE_BLOCK_STAR) && (ch == CH_SLASH)) begin
          st_nxt.mode = MODE_CODE;
        end else if (ch == CH_STAR) begin
          st_nxt.mode = MODE_BLOCK_STAR;
        end else begin
          if (ch == CH_NL) begin
            res0    = '{ch: CH_NL, vld: 1'b1, eot: 1'b0};
            res_cnt = 2'd1;
          end
          st_nxt.mode = MODE_BLOCK;
        end
      end
      MODE_QUOTE: begin
        res0    = '{ch: ch, vld: 1'b1, eot: 1'b0};
        res_cnt = 2'd1;
        if (ch == CH_BSLASH) begin
          st_nxt.mode = MODE_QUOTE_ESC;
        end else if (ch == quote_ch) begin
          st_nxt.mode = MODE_CODE;
          st_nxt.qs   = 1'b0;
        end
      end
      MODE_QUOTE_ESC: begin
        res0        = '{ch: ch, vld: 1'b1, eot: 1'b0};
        res_cnt     = 2'd1;
        st_nxt.mode = MODE_QUOTE;
      end
      default: begin
        st_nxt.mode = cb_mode;
        st_nxt.qs   = cb_qs;
        if (cb_emit) begin
          res0    = '{ch: ch, vld: 1'b1, eot: 1'b0};
          res_cnt = 2'd1;
        end
      end
    endcase

    if (is_final) begin
      // a slash still held at the end goes out as text
      if (st_nxt.mode == MODE_SLASH) begin
        if (res_cnt == 2'd0) begin
          res0    = '{ch: CH_SLASH, vld: 1'b1, eot: 1'b0};
          res_cnt = 2'd1;
        end else begin
          res1    = '{ch: CH_SLASH, vld: 1'b1, eot: 1'b0};
          res_cnt = 2'd2;
        end
      end
      if (res_cnt == 2'd0) begin
        res0    = '{ch: 8'h00, vld: 1'b0, eot: 1'b1};
        res_cnt = 2'd1;
      end else if (res_cnt == 2'd1) begin
        res0.eot = 1'b1;
      end else begin
        res1.eot = 1'b1;
      end
      st_nxt.mode = MODE_CODE;
      st_nxt.qs   = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/c_comment_stripper.sv =====
// C comment stripper: drops comments and '#' lines from a byte stream, keeps strings intact.
// One text byte is taken per cycle while in_stall is low; each result beat is registered into
// the queue before it reaches the output. Most bytes give zero or one result; the byte after a
// '/' that turns out not to open a comment can give two, and an end-of-text byte with nothing
// to send gives a bare end mark. Results sit in a three-entry queue that drains one beat per
// cycle while out_stall is low, and in_stall rises while two or more beats are waiting, so the
// input pauses after a two-result byte until fewer than two beats wait, and under out_stall.
module c_comment_stripper import ccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_end_of_text
);

  localparam int QDEPTH = 3;

  ccs_state_t st_r;
  ccs_state_t st_nxt;
  logic [1:0] res_cnt;
  ccs_res_t   res0;
  ccs_res_t   res1;

  ccs_res_t   q_r   [QDEPTH];
  ccs_res_t   q_nxt [QDEPTH];
  logic [1:0] occ_r;
  logic [1:0] occ_nxt;
  logic       push;
  logic       pop;

  ccs_step u_step (
    .st       (st_r),
    .ch       (in_char),
    .is_final (in_is_final),
    .st_nxt   (st_nxt),
    .res_cnt  (res_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  assign in_stall = occ_r[1];
  assign push     = in_valid && !in_stall;
  assign pop      = (occ_r != 2'd0) && !out_stall;

  always_comb begin
    q_nxt   = q_r;
    occ_nxt = occ_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      occ_nxt  = occ_nxt - 2'd1;
    end
    // push only when at most one beat is queued, so both writes land in range
    if (push && (res_cnt != 2'd0)) begin
      q_nxt[occ_nxt] = res0;
      occ_nxt        = occ_nxt + 2'd1;
      if (res_cnt == 2'd2) begin
        q_nxt[occ_nxt] = res1;
        occ_nxt        = occ_nxt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{mode: MODE_CODE, qs: 1'b0};
      occ_r <= 2'd0;
    end else begin
      if (push) begin
        st_r <= st_nxt;
      end
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_valid       = (occ_r != 2'd0);
  assign out_char        = q_r[0].ch;
  assign out_char_valid  = q_r[0].vld;
  assign out_end_of_text = q_r[0].eot;

`include "c_comment_stripper_assert.svh"

  `CCS_ASSERT_NEXT(a_final_resets, push && in_is_final, (st_r.mode == MODE_CODE) && !st_r.qs, "state not back to code after last byte")
  `CCS_ASSERT(a_qs_in_quote, st_r.qs |-> ((st_r.mode == MODE_QUOTE) || (st_r.mode == MODE_QUOTE_ESC)), "single-quote flag set outside a quote")
  `CCS_ASSERT(a_bare_mark_eot, (out_valid && !out_char_valid) |-> out_end_of_text, "empty beat without end mark")
  `CCS_ASSERT(a_full_after_push, (occ_r == 2'd3) |-> ($past(push) || $past(occ_r == 2'd3)), "queue reached three beats without a byte taken")

endmodule

// ===== tb/sv/c_comment_stripper_tb.sv =====
// Self-checking testbench for the C comment stripper: directed table, then random C-like text.
`timescale 1ns / 1ps

module c_comment_stripper_tb;
  import ccs_pkg::*;

  localparam int TOTAL_BYTES = 1700;
  localparam int HOLD_CYCLES = 200;
  localparam ccs_res_t NO_BEAT = '0;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    ccs_res_t   r0;
    ccs_res_t   r1;
  } dir_row_t;

  // typed rows carry their beats; the rest take the predictor's
  localparam dir_row_t DIR_ROWS [29] = '{
    '{8'h61,     1'b0, 1'b1, 2'd1, '{8'h61, 1'b1, 1'b0}, NO_BEAT},
    '{8'h00,     1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_BEAT},
    '{8'hFF,     1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h78,     1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h71,     1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_NL,     1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_STAR,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    // opening star must not close the comment
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_STAR,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_NL,     1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_STAR,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_HASH,   1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_NL,     1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SLASH,  1'b1, 1'b1, 2'd1, '{CH_SLASH, 1'b1, 1'b1}, NO_BEAT},
    '{CH_SLASH,  1'b0, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_STAR,   1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_BEAT},
    '{CH_SQUOTE, 1'b1, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h6B,     1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       in_is_final;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_end_of_text;

  logic [2:0] scan_st = MODE_CODE;
  logic       in_squote = 1'b0;
  ccs_res_t   step_beats [$];
  ccs_res_t   kept_beats [$];
  logic [7:0] text_q [$];
  int         err_count = 0;
  int         n_sent = 0;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;

  c_comment_stripper u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_is_final    (in_is_final),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_end_of_text(out_end_of_text)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---- predictor ----
  function automatic void add_beat(input ccs_res_t b);
    step_beats = {step_beats, b};
  endfunction

  function automatic void emit_beat(input logic [7:0] ch);
    add_beat(ccs_res_t'{ch, 1'b1, 1'b0});
  endfunction

  function automatic void code_mode_byte(input logic [7:0] ch);
    if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
      in_squote = (ch == CH_SQUOTE);
      scan_st = MODE_QUOTE;
      emit_beat(ch);
    end else if (ch == CH_SLASH) begin
      scan_st = MODE_SLASH;
    end else if (ch == CH_HASH) begin
      scan_st = MODE_LINE;
    end else begin
      scan_st = MODE_CODE;
      emit_beat(ch);
    end
  endfunction

  function automatic void strip_byte(input logic [7:0] ch, input logic fin);
    logic [7:0] closer;
    ccs_res_t   last;
    closer = in_squote ? CH_SQUOTE : CH_DQUOTE;
    step_beats.delete();
    case (scan_st)
      MODE_SLASH: begin
        if (ch == CH_SLASH) scan_st = MODE_LINE;
        else if (ch == CH_STAR) scan_st = MODE_BLOCK;
        else begin
          emit_beat(CH_SLASH);
          code_mode_byte(ch);
        end
      end
      MODE_LINE: begin
        if (ch == CH_NL) begin
          emit_beat(CH_NL);
          scan_st = MODE_CODE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (scan_st == MODE_BLOCK_STAR && ch == CH_SLASH) scan_st = MODE_CODE;
        else if (ch == CH_STAR) scan_st = MODE_BLOCK_STAR;
        else begin
          if (ch == CH_NL) emit_beat(CH_NL);
          scan_st = MODE_BLOCK;
        end
      end
      MODE_QUOTE: begin
        emit_beat(ch);
        if (ch == CH_BSLASH) scan_st = MODE_QUOTE_ESC;
        else if (ch == closer) begin
          scan_st = MODE_CODE;
          in_squote = 1'b0;
        end
      end
      MODE_QUOTE_ESC: begin
        emit_beat(ch);
        scan_st = MODE_QUOTE;
      end
      default: code_mode_byte(ch);
    endcase
    if (fin) begin
      if (scan_st == MODE_SLASH) emit_beat(CH_SLASH);
      if (step_beats.size() == 0) begin
        add_beat(ccs_res_t'{8'h00, 1'b0, 1'b1});
      end else begin
        last = step_beats.pop_back();
        last.eot = 1'b1;
        add_beat(last);
      end
      scan_st = MODE_CODE;
      in_squote = 1'b0;
    end
  endfunction

  // ---- random text ----
  function automatic void add_text(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic logic [7:0] pick_body();
    case ($urandom_range(0, 9))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_NL;
      3: return CH_BSLASH;
      4: return CH_DQUOTE;
      5: return CH_SQUOTE;
      6: return CH_HASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_token();
    int k;
    int len;
    logic [7:0] qc;
    k = $urandom_range(0, 99);
    len = $urandom_range(0, 6);
    if (k < 20) begin
      repeat (len + 1) add_text(8'($urandom_range(0, 255)));
    end else if (k < 35) begin
      repeat (len + 1) add_text(8'($urandom_range(8'h61, 8'h7A)));
    end else if (k < 50) begin
      qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      add_text(qc);
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) add_text(CH_BSLASH);
        add_text(pick_body());
      end
      add_text(qc);
    end else if (k < 60) begin
      if (k < 55) begin
        add_text(CH_SLASH);
        add_text(CH_SLASH);
      end else begin
        add_text(CH_HASH);
      end
      repeat (len) add_text(pick_body());
      add_text(CH_NL);
    end else if (k < 72) begin
      add_text(CH_SLASH);
      add_text(CH_STAR);
      repeat (len) add_text(pick_body());
      add_text(CH_STAR);
      add_text(CH_SLASH);
    end else if (k < 88) begin
      add_text(CH_SLASH);
      add_text(pick_body());
    end else begin
      add_text(CH_NL);
    end
  endfunction

  // offer one byte, wait until it is taken, then update the predictor
  task automatic drive_byte(input logic [7:0] ch, input logic fin);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_char     <= ch;
    in_is_final <= fin;
    do @(posedge clk); while (in_stall);
    n_sent++;
    strip_byte(ch, fin);
  endtask

  initial begin : stimulus
    int i;
    int drain;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_char     = '0;
    in_is_final = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (i = 0; i < 29; i++) begin
      drive_byte(DIR_ROWS[i].ch, DIR_ROWS[i].fin);
      if (DIR_ROWS[i].typed) begin
        if (DIR_ROWS[i].n > 0) kept_beats = {kept_beats, DIR_ROWS[i].r0};
        if (DIR_ROWS[i].n > 1) kept_beats = {kept_beats, DIR_ROWS[i].r1};
      end else begin
        kept_beats = {kept_beats, step_beats};
      end
    end

    hold_req = 1'b1;
    while (n_sent < TOTAL_BYTES) begin
      text_q.delete();
      repeat ($urandom_range(1, 10)) add_token();
      quiet = ($urandom_range(0, 4) == 0);
      for (i = 0; i < text_q.size(); i++) begin
        drive_byte(text_q[i], i == text_q.size() - 1);
        kept_beats = {kept_beats, step_beats};
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    drain = 0;
    while (kept_beats.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (kept_beats.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", kept_beats.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    int run_left;
    run_left  = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (run_left > 0) begin
        run_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        run_left = HOLD_CYCLES - 1;
      end else begin
        run_left = quiet ? 0 : pick_gap();
        out_stall <= (run_left > 0);
        if (run_left > 0) run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_out
    ccs_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (kept_beats.size() == 0) begin
        flag_error($sformatf("unexpected beat: char %02h vld %b eot %b",
                             out_char, out_char_valid, out_end_of_text));
      end else begin
        want = kept_beats.pop_front();
        if (out_char !== want.ch || out_char_valid !== want.vld ||
            out_end_of_text !== want.eot)
          flag_error($sformatf("beat mismatch: char %02h/%02h vld %b/%b eot %b/%b (exp/got)",
                               want.ch, out_char, want.vld, out_char_valid,
                               want.eot, out_end_of_text));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
